// ----- src/lrupr_pkg.sv -----
// ----------------------------------------------------------------------------
// lrupr_pkg : shared definitions for the lru page replacement block
// control state encoding, configuration and result field widths
// ----------------------------------------------------------------------------
package lrupr_pkg;

    // configuration register width and reset value
    localparam int CFG_W = 5;
    localparam logic [CFG_W-1:0] WAYS_RESET = 5'd16;

    // fixed result field widths
    localparam int SLOT_FIELD_W = 4;
    localparam int PAGE_FIELD_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ----- src/lrupr_cell.sv -----
// ----------------------------------------------------------------------------
// lrupr_cell : one slot of the lru page replacement chain
// holds tag, valid and recency rank; folds itself into the passing lookup
// record and applies the broadcast update
// ----------------------------------------------------------------------------
module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int PAGE_BITS = 16,
    parameter int IDX       = 0,
    localparam int SW       = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int SCAN_W   = 2 + 6 * SW + PAGE_BITS,
    localparam int UPD_W    = 2 + 2 * SW + PAGE_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [PAGE_BITS-1:0] page,
    input  logic [CFG_W-1:0]     ways,
    input  logic                 tok_in,
    input  logic [SCAN_W-1:0]    carry_in,
    input  logic [UPD_W-1:0]     upd_in,
    output logic                 tok_out,
    output logic [SCAN_W-1:0]    carry_out
);

    typedef struct packed {
        logic                 hit;
        logic [SW-1:0]        hit_slot;
        logic [SW-1:0]        hit_rank;
        logic                 free;
        logic [SW-1:0]        free_slot;
        logic [SW-1:0]        free_rank;
        logic [SW-1:0]        best_slot;
        logic [SW-1:0]        best_rank;
        logic [PAGE_BITS-1:0] best_tag;
    } scan_t;

    typedef struct packed {
        logic                 en;
        logic                 write;
        logic [SW-1:0]        slot;
        logic [SW-1:0]        old_rank;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

    localparam logic [SW-1:0] MY_SLOT = SW'(IDX);

    scan_t                c_in;
    scan_t                c_out_next;
    scan_t                c_out_reg;
    upd_t                 u;
    logic [PAGE_BITS-1:0] tag_reg;
    logic                 valid_reg;
    logic [SW-1:0]        rank_reg;
    logic                 tok_reg;
    logic                 in_use;
    logic                 match;

    assign c_in = carry_in;
    assign u    = upd_in;

    // slot zero always takes part
    assign in_use = (IDX == 0) || (32'(ways) > 32'(IDX));
    assign match  = in_use && valid_reg && (tag_reg == page);

    always_comb
    begin
        c_out_next = c_in;
        if (match && !c_in.hit)
        begin
            c_out_next.hit      = 1'b1;
            c_out_next.hit_slot = MY_SLOT;
            c_out_next.hit_rank = rank_reg;
        end
        if (in_use && !valid_reg && !c_in.free)
        begin
            c_out_next.free      = 1'b1;
            c_out_next.free_slot = MY_SLOT;
            c_out_next.free_rank = rank_reg;
        end
        if (in_use && (rank_reg >= c_in.best_rank))
        begin
            c_out_next.best_slot = MY_SLOT;
            c_out_next.best_rank = rank_reg;
            c_out_next.best_tag  = tag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok_in)
        begin
            c_out_reg <= c_out_next;
        end
    end

    // recency and valid state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            rank_reg  <= MY_SLOT;
        end
        else if (u.en)
        begin
            if (u.slot == MY_SLOT)
            begin
                rank_reg <= '0;
                if (u.write)
                begin
                    valid_reg <= 1'b1;
                end
            end
            else if (rank_reg < u.old_rank)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (u.en && u.write && (u.slot == MY_SLOT))
        begin
            tag_reg <= u.page;
        end
    end

    assign tok_out   = tok_reg;
    assign carry_out = c_out_reg;

endmodule

// ----- src/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement : fully associative page cache with lru replacement
// one page access in, one hit / slot / eviction result out
// ----------------------------------------------------------------------------
// Each accepted page transaction is looked up against every slot in use
// (slots 0 .. ways_in_use-1; a ways value of 0 acts as 1, above SLOTS as
// SLOTS). A hit makes that slot the most recent; a miss fills the lowest
// free slot, or else replaces the least recently used slot in use and
// reports the page it held. The slots form a chain of cells: a lookup
// record enters the first cell in the cycle after acceptance and moves
// one cell per cycle, each cell folding in its own tag, valid bit and
// rank, so the time from acceptance to a result is set by the length of
// that chain. The update (fill and ageing) is broadcast to every cell in
// the cycle the result is loaded into the output register. One access is
// worked on at a time, so a new access is taken only after the last one
// has been loaded into the output register, and later while that register
// stays full; a new one is taken while an earlier result still waits on
// out_ready. ways_in_use is written through cfg_wr_en and cfg_wr_data and
// is expected to change only while no access is in flight.
// ----------------------------------------------------------------------------
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int PAGE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PAGE_FIELD_W-1:0] page,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    hit,
    output logic [SLOT_FIELD_W-1:0] slot,
    output logic                    evicted,
    output logic [PAGE_FIELD_W-1:0] evicted_page
);

    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SCAN_W = 2 + 6 * SW + PAGE_BITS;
    localparam int UPD_W  = 2 + 2 * SW + PAGE_BITS;

    // lookup record carried along the chain
    typedef struct packed {
        logic                 hit;
        logic [SW-1:0]        hit_slot;
        logic [SW-1:0]        hit_rank;
        logic                 free;
        logic [SW-1:0]        free_slot;
        logic [SW-1:0]        free_rank;
        logic [SW-1:0]        best_slot;
        logic [SW-1:0]        best_rank;
        logic [PAGE_BITS-1:0] best_tag;
    } scan_t;

    // update broadcast to every cell
    typedef struct packed {
        logic                 en;
        logic                 write;
        logic [SW-1:0]        slot;
        logic [SW-1:0]        old_rank;
        logic [PAGE_BITS-1:0] page;
    } upd_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [CFG_W-1:0]               ways_reg;
    logic                           start_reg;
    logic [PAGE_BITS-1:0]           page_reg;
    logic [PAGE_FIELD_W+PAGE_BITS-1:0] page_ext;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           hit_reg;
    logic [SLOT_FIELD_W-1:0]        slot_reg;
    logic                           evicted_reg;
    logic [PAGE_FIELD_W-1:0]        evicted_page_reg;

    logic                           drain;
    logic                           in_accept;
    logic [SLOTS:0]                 tok_vec;
    logic [SCAN_W-1:0]              carry_bus [SLOTS+1];
    logic [UPD_W-1:0]               upd_bus;
    scan_t                          sc;
    upd_t                           upd;

    logic                           res_evicted;
    logic [SW+SLOT_FIELD_W-1:0]     slot_ext;
    logic [PAGE_BITS+PAGE_FIELD_W-1:0] ev_ext;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ways_reg <= WAYS_RESET;
        end
        else if (cfg_wr_en)
        begin
            ways_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // control: idle -> scan along the chain -> done until result drains
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok_vec[SLOTS])
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (drain)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        drain    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DONE:
            begin
                // output register free or being emptied this cycle
                drain = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
                drain    = 1'b0;
            end
        endcase
    end

    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= in_accept;
        end
    end

    // page masked to PAGE_BITS
    assign page_ext = {{PAGE_BITS{1'b0}}, page};

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            page_reg <= page_ext[PAGE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // chain of slot cells
    // ------------------------------------------------------------------
    assign tok_vec[0]   = start_reg;
    assign carry_bus[0] = '0;
    assign upd_bus      = upd;

    for (genvar k = 0; k < SLOTS; k++)
    begin : g_cell
        lrupr_cell #(
            .SLOTS     (SLOTS),
            .PAGE_BITS (PAGE_BITS),
            .IDX       (k)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .page      (page_reg),
            .ways      (ways_reg),
            .tok_in    (tok_vec[k]),
            .carry_in  (carry_bus[k]),
            .upd_in    (upd_bus),
            .tok_out   (tok_vec[k+1]),
            .carry_out (carry_bus[k+1])
        );
    end

    // record left by the last cell, held until the next lookup
    assign sc = carry_bus[SLOTS];

    // ------------------------------------------------------------------
    // decision: hit, else lowest free slot, else oldest slot in use
    // ------------------------------------------------------------------
    always_comb
    begin
        upd.en      = drain;
        upd.page    = page_reg;
        upd.write   = !sc.hit;
        res_evicted = 1'b0;
        if (sc.hit)
        begin
            upd.slot     = sc.hit_slot;
            upd.old_rank = sc.hit_rank;
        end
        else if (sc.free)
        begin
            upd.slot     = sc.free_slot;
            upd.old_rank = sc.free_rank;
        end
        else
        begin
            upd.slot     = sc.best_slot;
            upd.old_rank = sc.best_rank;
            res_evicted  = 1'b1;
        end
    end

    assign slot_ext = {{SLOT_FIELD_W{1'b0}}, upd.slot};
    assign ev_ext   = {{PAGE_FIELD_W{1'b0}}, sc.best_tag};

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        if (drain)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (drain)
        begin
            hit_reg          <= sc.hit;
            slot_reg         <= slot_ext[SLOT_FIELD_W-1:0];
            evicted_reg      <= res_evicted;
            evicted_page_reg <= res_evicted ? ev_ext[PAGE_FIELD_W-1:0] : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign slot         = slot_reg;
    assign evicted      = evicted_reg;
    assign evicted_page = evicted_page_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    // only one lookup record travels the chain at a time
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_vec))
        else $error("more than one lookup record in the chain");

    // no record in flight while idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (tok_vec == '0))
        else $error("lookup record in flight while idle");

    // the record reaches the end of the chain only during a scan
    a_end_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok_vec[SLOTS] |-> (state_reg == ST_SCAN))
        else $error("chain finished outside a scan");

    // an update leaves the block idle in the next cycle with a result shown
    a_drain_result: assert property (@(posedge clk) disable iff (!rst_n)
        drain |=> (out_valid_reg && (state_reg == ST_IDLE)))
        else $error("update without a result");

endmodule
